// ===== rtl/core/bldc_pkg.sv =====
// Package for the button LED dimmer controller.
// Holds register index codes, field widths and the structs shared by the core
// modules. No dependencies.
package bldc_pkg;

  localparam int unsigned PeriodW   = 16;
  localparam int unsigned DelayW    = 20;
  localparam int unsigned PressW    = 3;
  localparam int unsigned LedW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 8;

  localparam logic [PressW-1:0] PressMax = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD    = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_WINDOW    = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PeriodW-1:0] period_ticks;
    logic [DelayW-1:0]  debounce_ticks;
    logic [DelayW-1:0]  window_ticks;
    logic [PressW-1:0]  press_threshold;
  } cfg_t;

  // Button side status after the current tick, consumed by the PWM side.
  typedef struct packed {
    logic enabled;
    logic held;
  } btn_status_t;

endpackage

// ===== rtl/core/bldc_btn.sv =====
// Button side of the dimmer: debounce delay, held flag, press window, enable.
// Depends on bldc_pkg.
module bldc_btn (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 level_i,
  input  bldc_pkg::cfg_t       cfg_i,
  output bldc_pkg::btn_status_t status_o
);

  logic [bldc_pkg::DelayW-1:0] deb_q, deb_d;
  logic [bldc_pkg::DelayW-1:0] win_q, win_d;
  logic [bldc_pkg::PressW-1:0] press_q, press_d;
  logic                        en_q, en_d;
  logic                        held_q, held_d;
  logic                        last_q;

  logic [bldc_pkg::DelayW-1:0] win_dec;
  logic                        win_end;

  always_comb begin
    win_dec = win_q - 1'b1;
    win_end = (win_q != '0) && (win_dec == '0);
    win_d   = (win_q != '0) ? win_dec : win_q;
    press_d = press_q;
    en_d    = en_q;
    held_d  = held_q;
    deb_d   = deb_q;

    // Window is judged before the debounce sample of the same tick.
    if (win_end) begin
      if (press_q >= cfg_i.press_threshold) begin
        en_d = !en_q;
      end
      press_d = '0;
    end

    if (level_i != last_q) begin
      deb_d = cfg_i.debounce_ticks;
    end else if (deb_q != '0) begin
      deb_d = deb_q - 1'b1;
      if (deb_q == bldc_pkg::DelayW'(1)) begin
        if (level_i) begin
          held_d = 1'b1;
          if (press_d < bldc_pkg::PressMax) begin
            press_d = press_d + 1'b1;
          end
          win_d = cfg_i.window_ticks;
        end else begin
          held_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= '0;
      win_q   <= '0;
      press_q <= '0;
      en_q    <= 1'b1;
      held_q  <= 1'b0;
      last_q  <= 1'b0;
    end else if (tick_i) begin
      deb_q   <= deb_d;
      win_q   <= win_d;
      press_q <= press_d;
      en_q    <= en_d;
      held_q  <= held_d;
      last_q  <= level_i;
    end
  end

  assign status_o.enabled = en_d;
  assign status_o.held    = held_d;

endmodule

// ===== rtl/core/bldc_pwm.sv =====
// PWM side of the dimmer: phase counter, bouncing duty ramp, LED selection.
// Depends on bldc_pkg.
module bldc_pwm #(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  bldc_pkg::btn_status_t       status_i,
  input  logic [bldc_pkg::PeriodW-1:0] period_i,
  output logic [bldc_pkg::LedW-1:0]   led_index_o,
  output logic                        led_lit_o
);

  localparam logic [bldc_pkg::LedW-1:0] LedNone = bldc_pkg::LedW'(LED_COUNT);
  localparam logic [bldc_pkg::LedW-1:0] LedLast = bldc_pkg::LedW'(LED_COUNT - 1);

  logic [bldc_pkg::PeriodW-1:0] duty_q, duty_d;
  logic [bldc_pkg::PeriodW-1:0] phase_q, phase_d;
  logic [bldc_pkg::LedW-1:0]    sel_q, sel_d;
  logic                         up_q, up_d;
  logic                         step;
  logic [bldc_pkg::PeriodW:0]   phase_inc;

  always_comb begin
    duty_d = duty_q;
    up_d   = up_q;
    sel_d  = sel_q;
    step   = status_i.enabled && status_i.held && (phase_q == '0) && (period_i != '0);

    if (step) begin
      if (duty_q >= period_i) begin
        up_d = 1'b0;
      end else if (duty_q == '0) begin
        up_d  = 1'b1;
        sel_d = (sel_q >= LedLast) ? '0 : sel_q + 1'b1;
      end
      if (up_d) begin
        if (duty_q != '1) begin
          duty_d = duty_q + 1'b1;
        end
      end else if (duty_q != '0) begin
        duty_d = duty_q - 1'b1;
      end
    end

    // Phase can sit above a lowered period; the wrap still catches it.
    phase_inc = {1'b0, phase_q} + 1'b1;
    phase_d   = (phase_inc >= {1'b0, period_i}) ? '0 : phase_inc[bldc_pkg::PeriodW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q  <= '0;
      up_q    <= 1'b1;
      sel_q   <= LedNone;
      phase_q <= '0;
    end else if (tick_i) begin
      duty_q  <= duty_d;
      up_q    <= up_d;
      sel_q   <= sel_d;
      phase_q <= phase_d;
    end
  end

  assign led_index_o = sel_d;
  assign led_lit_o   = status_i.enabled && (sel_d < LedNone) && (phase_q < duty_d);

endmodule

// ===== rtl/core/button_led_dimmer_controller_top.sv =====
// Top level of the button LED dimmer controller: stream ports, config
// registers, output register. Depends on bldc_pkg, bldc_btn and bldc_pwm.
// An accepted tick item's result is in the output register in the next cycle.
// One item per cycle unless m_axis_tready stalls; the register refills as it drains.
// Reset: asynchronous active low; clears all dimmer state and loads the
// default config (period 1000, debounce 50000, window 500000, threshold 2).
module button_led_dimmer_controller_top #(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: [0] button_level, [7:1] zero
  input  logic [bldc_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [2:0] led_index, [3] led_lit, [4] enabled, [5] held, [7:6] zero
  output logic [bldc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bldc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bldc_pkg::CfgDataW-1:0]  cfg_data_i
);

  bldc_pkg::cfg_t        cfg_q;
  bldc_pkg::btn_status_t status;
  logic                  tick;
  logic [bldc_pkg::LedW-1:0] led_index;
  logic                  led_lit;
  logic                  out_valid_q;
  logic [bldc_pkg::OutDataW-1:0] out_data_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks    <= bldc_pkg::PeriodW'(1000);
      cfg_q.debounce_ticks  <= bldc_pkg::DelayW'(50000);
      cfg_q.window_ticks    <= bldc_pkg::DelayW'(500000);
      cfg_q.press_threshold <= bldc_pkg::PressW'(2);
    end else if (cfg_valid_i) begin
      unique case (bldc_pkg::cfg_reg_e'(cfg_index_i))
        bldc_pkg::REG_PERIOD:
          cfg_q.period_ticks <= cfg_data_i[bldc_pkg::PeriodW-1:0];
        bldc_pkg::REG_DEBOUNCE:
          cfg_q.debounce_ticks <= cfg_data_i[bldc_pkg::DelayW-1:0];
        bldc_pkg::REG_WINDOW:
          cfg_q.window_ticks <= cfg_data_i[bldc_pkg::DelayW-1:0];
        bldc_pkg::REG_THRESHOLD:
          cfg_q.press_threshold <= cfg_data_i[bldc_pkg::PressW-1:0];
        default: begin
        end
      endcase
    end
  end

  bldc_btn u_btn (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .level_i  (s_axis_tdata[0]),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  bldc_pwm #(
    .LED_COUNT (LED_COUNT)
  ) u_pwm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .status_i    (status),
    .period_i    (cfg_q.period_ticks),
    .led_index_o (led_index),
    .led_lit_o   (led_lit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_data_q <= {2'b00, status.held, status.enabled, led_lit, led_index};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A lit LED needs the dimmer enabled and a real LED selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[4])
    else $error("lit LED while disabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tdata[2:0] < bldc_pkg::LedW'(LED_COUNT)))
    else $error("lit LED with no selection");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

// ===== sim/button_led_dimmer_controller_top_tb.sv =====
// Self-checking testbench for button_led_dimmer_controller_top: streams button ticks,
// predicts every LED/enable/held result in-line and compares each one as it arrives.
// Depends on bldc_pkg and the RTL of the dimmer.
module button_led_dimmer_controller_top_tb;

  localparam int unsigned LedCount   = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrinted = 200;

  typedef struct packed {
    logic                      held;
    logic                      enabled;
    logic                      lit;
    logic [bldc_pkg::LedW-1:0] led;
  } dim_out_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic [bldc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bldc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [bldc_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [bldc_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  button_led_dimmer_controller_top #(
    .LED_COUNT(LedCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  logic         tick_q[$];
  dim_out_t     dimmer_exp_q[$];
  int unsigned  send_idle_pct = 7;
  int unsigned  recv_idle_pct = 68;
  int unsigned  fail_count    = 0;
  int unsigned  cycle_count   = 0;

  // Dimmer shadow: configuration and state
  bldc_pkg::cfg_t                dimmer_cfg;
  logic [bldc_pkg::PeriodW-1:0]  pwm_duty;
  logic                          duty_rising;
  logic [bldc_pkg::LedW-1:0]     led_sel;
  logic [bldc_pkg::PeriodW-1:0]  pwm_phase;
  logic [bldc_pkg::DelayW-1:0]   settle_left;
  logic [bldc_pkg::DelayW-1:0]   win_left;
  logic [bldc_pkg::PressW-1:0]   presses;
  logic                          dim_enabled;
  logic                          btn_held;
  logic                          prev_level;

  function automatic void dimmer_reset();
    dimmer_cfg.period_ticks    = 16'd1000;
    dimmer_cfg.debounce_ticks  = 20'd50000;
    dimmer_cfg.window_ticks    = 20'd500000;
    dimmer_cfg.press_threshold = 3'd2;
    pwm_duty    = '0;
    duty_rising = 1'b1;
    led_sel     = bldc_pkg::LedW'(LedCount);
    pwm_phase   = '0;
    settle_left = '0;
    win_left    = '0;
    presses     = '0;
    dim_enabled = 1'b1;
    btn_held    = 1'b0;
    prev_level  = 1'b0;
  endfunction

  // One microsecond tick: window first, then debounce, then PWM.
  function automatic dim_out_t dimmer_tick(input logic level);
    dim_out_t    res;
    int unsigned nxt;
    if (win_left != 0) begin
      win_left = win_left - 1'b1;
      if (win_left == 0) begin
        if (presses >= dimmer_cfg.press_threshold) dim_enabled = !dim_enabled;
        presses = '0;
      end
    end
    if (level != prev_level) begin
      settle_left = dimmer_cfg.debounce_ticks;
    end else if (settle_left != 0) begin
      settle_left = settle_left - 1'b1;
      if (settle_left == 0) begin
        if (level) begin
          btn_held = 1'b1;
          if (presses < bldc_pkg::PressMax) presses = presses + 1'b1;
          win_left = dimmer_cfg.window_ticks;
        end else begin
          btn_held = 1'b0;
        end
      end
    end
    prev_level = level;
    if (dim_enabled && btn_held && pwm_phase == 0 && dimmer_cfg.period_ticks != 0) begin
      // duty bounces between zero and the period; each bottom selects the next LED
      if (pwm_duty >= dimmer_cfg.period_ticks) begin
        duty_rising = 1'b0;
      end else if (pwm_duty == 0) begin
        duty_rising = 1'b1;
        led_sel = (int'(led_sel) >= LedCount - 1) ? '0 : led_sel + 1'b1;
      end
      if (duty_rising) begin
        if (pwm_duty < 16'hFFFF) pwm_duty = pwm_duty + 1'b1;
      end else if (pwm_duty > 0) begin
        pwm_duty = pwm_duty - 1'b1;
      end
    end
    res.led     = led_sel;
    res.lit     = dim_enabled && (int'(led_sel) < LedCount) && (pwm_phase < pwm_duty);
    res.enabled = dim_enabled;
    res.held    = btn_held;
    nxt = int'(pwm_phase) + 1;
    pwm_phase = (nxt >= int'(dimmer_cfg.period_ticks)) ? '0 : bldc_pkg::PeriodW'(nxt);
    return res;
  endfunction

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Sender: holds tvalid until the item is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bldc_pkg::InDataW'(tick_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i) begin
    dim_out_t got;
    dim_out_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) dimmer_exp_q.push_back(dimmer_tick(s_axis_tdata[0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (dimmer_exp_q.size() == 0) begin
          report_error("result with nothing expected");
        end else begin
          got  = dim_out_t'(m_axis_tdata[5:0]);
          want = dimmer_exp_q.pop_front();
          check_field("led_index", got.led, want.led);
          check_field("led_lit", got.lit, want.lit);
          check_field("enabled", got.enabled, want.enabled);
          check_field("held", got.held, want.held);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_ticks(input logic level, input int unsigned n);
    repeat (n) tick_q.push_back(level);
  endtask

  // Checked away from the rising edge so the driver and checker have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || dimmer_exp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input bldc_pkg::cfg_reg_e idx,
                           input logic [bldc_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      bldc_pkg::REG_PERIOD:
        dimmer_cfg.period_ticks    = value[bldc_pkg::PeriodW-1:0];
      bldc_pkg::REG_DEBOUNCE:
        dimmer_cfg.debounce_ticks  = value[bldc_pkg::DelayW-1:0];
      bldc_pkg::REG_WINDOW:
        dimmer_cfg.window_ticks    = value[bldc_pkg::DelayW-1:0];
      bldc_pkg::REG_THRESHOLD:
        dimmer_cfg.press_threshold = value[bldc_pkg::PressW-1:0];
      default: ;
    endcase
  endtask

  // Mostly clean presses that outlast the debounce, some long holds to walk
  // the duty ramp, plus glitch bursts and released stretches.
  task automatic add_button_activity(input int unsigned n, input int unsigned deb);
    int unsigned added;
    int unsigned pick;
    int unsigned hold;
    int unsigned rel;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        hold = deb + 1 + $urandom_range(0, 4);
        if ($urandom_range(3) == 0) hold += $urandom_range(10, 60);
        rel = deb + 1 + $urandom_range(0, 4);
        add_ticks(1'b1, hold);
        add_ticks(1'b0, rel);
        added += hold + rel;
      end else if (pick < 85) begin
        hold = $urandom_range(1, 4);
        repeat (hold) tick_q.push_back(1'($urandom_range(1)));
        added += hold;
      end else begin
        hold = $urandom_range(1, 20);
        add_ticks(1'b0, hold);
        added += hold;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned deb;
    dimmer_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: debounce far longer than these few ticks
    add_ticks(1'b0, 1);
    add_ticks(1'b1, 2);
    add_ticks(1'b0, 1);
    wait_drained();

    // all registers set to 1: one-tick debounce and window, period 1, threshold 1
    write_reg(bldc_pkg::REG_PERIOD, 20'd1);
    write_reg(bldc_pkg::REG_DEBOUNCE, 20'd1);
    write_reg(bldc_pkg::REG_WINDOW, 20'd1);
    write_reg(bldc_pkg::REG_THRESHOLD, 20'd1);
    add_ticks(1'b1, 2);
    add_ticks(1'b0, 2);
    add_ticks(1'b1, 4);
    add_ticks(1'b0, 2);
    wait_drained();

    // all registers at their maximum
    write_reg(bldc_pkg::REG_PERIOD, 20'd65535);
    write_reg(bldc_pkg::REG_DEBOUNCE, 20'hFFFFF);
    write_reg(bldc_pkg::REG_WINDOW, 20'hFFFFF);
    write_reg(bldc_pkg::REG_THRESHOLD, 20'd7);
    add_ticks(1'b1, 2);
    add_ticks(1'b0, 1);
    add_ticks(1'b1, 2);
    add_ticks(1'b0, 1);
    wait_drained();

    for (ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin send_idle_pct = 7;  recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // small periods let the duty bounce and the LED walk within a phase;
      // odd phases use longer ones so the next phase may start with duty above period
      if (ph == 3) write_reg(bldc_pkg::REG_PERIOD, 20'd65535);
      else if (ph % 2 == 1) write_reg(bldc_pkg::REG_PERIOD, 20'($urandom_range(5, 12)));
      else write_reg(bldc_pkg::REG_PERIOD, 20'($urandom_range(1, 4)));
      deb = ($urandom_range(3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      write_reg(bldc_pkg::REG_DEBOUNCE, 20'(deb));
      // window at its maximum lets the press count saturate
      if (ph == 7) write_reg(bldc_pkg::REG_WINDOW, 20'hFFFFF);
      else write_reg(bldc_pkg::REG_WINDOW, 20'($urandom_range(4, 40)));
      if ($urandom_range(1) == 1) begin
        write_reg(bldc_pkg::REG_THRESHOLD, 20'($urandom_range(1, 3)));
      end else begin
        write_reg(bldc_pkg::REG_THRESHOLD, 20'($urandom_range(1, 7)));
      end
      add_button_activity(20, deb);
      if (ph == 5) wait_drained();  // stimulus holds off until the pipe is empty
      add_button_activity(20, deb);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
